// ----- hw/rtl/usb_control_endpoint_responder_defines.svh -----
// assertion helpers used by the responder back end (ucer_back)
`ifndef USB_CONTROL_ENDPOINT_RESPONDER_DEFINES_SVH
`define USB_CONTROL_ENDPOINT_RESPONDER_DEFINES_SVH

// same-cycle implication, idle during reset
`define UCER_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define UCER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ucer_pkg.sv -----
`timescale 1ns / 1ps

package ucer_pkg;

    localparam int ADDR_W      = 7;
    localparam int CONF_W      = 4;
    localparam int LEN_W       = 8;
    localparam int NUM_DESC    = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        EVT_SETUP     = 2'd0,
        EVT_OUT_DATA  = 2'd1,
        EVT_IN_DONE   = 2'd2,
        EVT_BUS_RESET = 2'd3
    } evt_kind_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_SEND  = 3'd1,
        ACT_ZLP   = 3'd2,
        ACT_DONE  = 3'd3,
        ACT_ERROR = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_SEND       = 3'd1,
        OP_SET_ADDR   = 3'd2,
        OP_SET_CONFIG = 3'd3,
        OP_ERROR      = 3'd4,
        OP_IN_DONE    = 3'd5,
        OP_BUS_RESET  = 3'd6
    } cmd_op_t;

    typedef enum logic [2:0] {
        REG_CONFIG_VALUE = 3'd0,
        REG_DEVICE_LEN   = 3'd1,
        REG_CONFIG_LEN   = 3'd2,
        REG_QUAL_LEN     = 3'd3,
        REG_LANG_LEN     = 3'd4,
        REG_VENDOR_LEN   = 3'd5,
        REG_PRODUCT_LEN  = 3'd6,
        REG_SERIAL_LEN   = 3'd7
    } reg_index_t;

    // descriptor selects
    localparam logic [2:0] SEL_DEVICE = 3'd0;
    localparam logic [2:0] SEL_CONFIG = 3'd1;
    localparam logic [2:0] SEL_QUAL   = 3'd2;
    localparam logic [2:0] SEL_LANG   = 3'd3;

    // standard request fields
    localparam logic [7:0] RT_DEV_TO_HOST = 8'h80;
    localparam logic [7:0] RT_HOST_TO_DEV = 8'h00;
    localparam logic [7:0] RC_SET_ADDRESS = 8'd5;
    localparam logic [7:0] RC_GET_DESC    = 8'd6;
    localparam logic [7:0] RC_SET_CONFIG  = 8'd9;
    localparam logic [7:0] DT_DEVICE      = 8'd1;
    localparam logic [7:0] DT_CONFIG      = 8'd2;
    localparam logic [7:0] DT_STRING      = 8'd3;
    localparam logic [7:0] DT_QUALIFIER   = 8'd6;
    localparam logic [7:0] MAX_STRING_IDX = 8'd3;

    localparam logic [CONF_W-1:0] CONFIG_VALUE_RST = 4'd1;
    localparam logic [NUM_DESC-1:0][LEN_W-1:0] DESC_LEN_RST =
        {8'd24, 8'd28, 8'd30, 8'd4, 8'd10, 8'd32, 8'd18};

    typedef struct packed {
        logic [CONF_W-1:0]                config_value;
        logic [NUM_DESC-1:0][LEN_W-1:0]   desc_len;
    } cfg_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [2:0]         sel;
        logic [LEN_W-1:0]   tx_length;
        logic [ADDR_W-1:0]  value;
    } cmd_t;

endpackage

// ----- hw/rtl/ucer_if.sv -----
`timescale 1ns / 1ps

interface ucer_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [9:0]  received_bytes;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;

    modport source (
        output valid, event_kind, received_bytes, request_type, request_code,
               request_value, request_length,
        input  ready
    );
    modport sink (
        input  valid, event_kind, received_bytes, request_type, request_code,
               request_value, request_length,
        output ready
    );
endinterface

interface ucer_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [2:0] descriptor_select;
    logic [7:0] tx_length;
    logic [6:0] device_address;
    logic       address_updated;
    logic       configured;
    logic       start_bulk_in;

    modport source (
        output valid, action, descriptor_select, tx_length, device_address,
               address_updated, configured, start_bulk_in,
        input  ready
    );
    modport sink (
        input  valid, action, descriptor_select, tx_length, device_address,
               address_updated, configured, start_bulk_in,
        output ready
    );
endinterface

// ----- hw/rtl/ucer_front.sv -----
`timescale 1ns / 1ps

module ucer_front (
    ucer_event_if.sink       req,
    input  ucer_pkg::cfg_t   cfg,
    input  logic             queue_ready,
    output logic             push,
    output ucer_pkg::cmd_t   cmd
);

    logic                       long_enough;
    logic                       desc_ok;
    logic [2:0]                 desc_sel;
    logic [ucer_pkg::LEN_W-1:0] desc_len;
    logic [7:0]                 dtype;
    logic [7:0]                 didx;

    assign req.ready   = queue_ready;
    assign push        = req.valid && queue_ready;
    assign long_enough = (req.received_bytes[9:3] != 7'd0);
    assign dtype       = req.request_value[15:8];
    assign didx        = req.request_value[7:0];

    always_comb
    begin
        desc_ok  = 1'b1;
        desc_sel = ucer_pkg::SEL_DEVICE;
        case (dtype)
            ucer_pkg::DT_DEVICE:    desc_sel = ucer_pkg::SEL_DEVICE;
            ucer_pkg::DT_CONFIG:    desc_sel = ucer_pkg::SEL_CONFIG;
            ucer_pkg::DT_QUALIFIER: desc_sel = ucer_pkg::SEL_QUAL;
            ucer_pkg::DT_STRING:
            begin
                desc_ok  = (didx <= ucer_pkg::MAX_STRING_IDX);
                desc_sel = ucer_pkg::SEL_LANG + didx[2:0];
            end
            default:                desc_ok = 1'b0;
        endcase
    end

    // string index is at most 3 when used, so the select stays below seven
    assign desc_len = cfg.desc_len[desc_sel];

    always_comb
    begin
        cmd           = '0;
        cmd.op        = ucer_pkg::OP_NONE;
        case (ucer_pkg::evt_kind_t'(req.event_kind))
            ucer_pkg::EVT_SETUP:
            begin
                cmd.op = ucer_pkg::OP_ERROR;
                if (long_enough)
                begin
                    if (req.request_type == ucer_pkg::RT_DEV_TO_HOST &&
                        req.request_code == ucer_pkg::RC_GET_DESC && desc_ok)
                    begin
                        cmd.op        = ucer_pkg::OP_SEND;
                        cmd.sel       = desc_sel;
                        // clamp the host length to the descriptor length
                        cmd.tx_length = (req.request_length < {8'd0, desc_len}) ?
                                        req.request_length[7:0] : desc_len;
                    end
                    else if (req.request_type == ucer_pkg::RT_HOST_TO_DEV &&
                             req.request_code == ucer_pkg::RC_SET_ADDRESS)
                    begin
                        cmd.op    = ucer_pkg::OP_SET_ADDR;
                        cmd.value = req.request_value[ucer_pkg::ADDR_W-1:0];
                    end
                    else if (req.request_type == ucer_pkg::RT_HOST_TO_DEV &&
                             req.request_code == ucer_pkg::RC_SET_CONFIG)
                    begin
                        cmd.op    = ucer_pkg::OP_SET_CONFIG;
                        cmd.value = {3'd0, req.request_value[ucer_pkg::CONF_W-1:0]};
                    end
                end
            end
            ucer_pkg::EVT_OUT_DATA:  cmd.op = ucer_pkg::OP_NONE;
            ucer_pkg::EVT_IN_DONE:   cmd.op = ucer_pkg::OP_IN_DONE;
            ucer_pkg::EVT_BUS_RESET: cmd.op = ucer_pkg::OP_BUS_RESET;
            default:                 cmd.op = ucer_pkg::OP_NONE;
        endcase
    end

endmodule

// ----- hw/rtl/ucer_queue.sv -----
`timescale 1ns / 1ps

module ucer_queue #(
    parameter int DEPTH = ucer_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ucer_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            not_full,
    output logic            not_empty,
    output ucer_pkg::cmd_t  head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    ucer_pkg::cmd_t  slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign not_full  = (count_reg != FULL);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- hw/rtl/ucer_back.sv -----
`timescale 1ns / 1ps
`include "usb_control_endpoint_responder_defines.svh"

module ucer_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ucer_pkg::CONF_W-1:0]  config_value,
    input  logic                         cmd_valid,
    input  ucer_pkg::cmd_t               cmd,
    output logic                         pop,
    ucer_result_if.source                rsp
);

    logic [ucer_pkg::ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [ucer_pkg::CONF_W-1:0] pend_conf_reg, pend_conf_next;
    logic [ucer_pkg::ADDR_W-1:0] cur_addr_reg, cur_addr_next;
    logic                        configured_reg, configured_next;
    logic                        out_valid_reg;

    ucer_pkg::action_t           action_reg, action_next;
    logic [2:0]                  sel_reg, sel_next;
    logic [ucer_pkg::LEN_W-1:0]  tx_len_reg, tx_len_next;
    logic                        addr_upd_reg, addr_upd_next;
    logic                        bulk_reg, bulk_next;

    // take a command whenever the output register is free or being emptied
    assign pop = cmd_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        pend_addr_next  = pend_addr_reg;
        pend_conf_next  = pend_conf_reg;
        cur_addr_next   = cur_addr_reg;
        configured_next = configured_reg;
        action_next     = ucer_pkg::ACT_NONE;
        sel_next        = '0;
        tx_len_next     = '0;
        addr_upd_next   = 1'b0;
        bulk_next       = 1'b0;
        case (cmd.op)
            ucer_pkg::OP_NONE:       action_next = ucer_pkg::ACT_NONE;
            ucer_pkg::OP_ERROR:      action_next = ucer_pkg::ACT_ERROR;
            ucer_pkg::OP_SEND:
            begin
                action_next = ucer_pkg::ACT_SEND;
                sel_next    = cmd.sel;
                tx_len_next = cmd.tx_length;
            end
            ucer_pkg::OP_SET_ADDR:
            begin
                action_next    = ucer_pkg::ACT_ZLP;
                pend_addr_next = cmd.value;
            end
            ucer_pkg::OP_SET_CONFIG:
            begin
                action_next    = ucer_pkg::ACT_ZLP;
                pend_conf_next = cmd.value[ucer_pkg::CONF_W-1:0];
            end
            ucer_pkg::OP_IN_DONE:
            begin
                action_next = ucer_pkg::ACT_DONE;
                // zero pending means nothing pending
                if (pend_addr_reg != '0)
                begin
                    cur_addr_next  = pend_addr_reg;
                    addr_upd_next  = 1'b1;
                    pend_addr_next = '0;
                end
                if (pend_conf_reg != '0)
                begin
                    if (pend_conf_reg == config_value)
                    begin
                        configured_next = 1'b1;
                        bulk_next       = 1'b1;
                    end
                    pend_conf_next = '0;
                end
            end
            ucer_pkg::OP_BUS_RESET:
            begin
                addr_upd_next   = (cur_addr_reg != '0);
                cur_addr_next   = '0;
                pend_addr_next  = '0;
                pend_conf_next  = '0;
                configured_next = 1'b0;
            end
            default:                 action_next = ucer_pkg::ACT_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_addr_reg  <= '0;
            pend_conf_reg  <= '0;
            cur_addr_reg   <= '0;
            configured_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pend_addr_reg  <= pend_addr_next;
                pend_conf_reg  <= pend_conf_next;
                cur_addr_reg   <= cur_addr_next;
                configured_reg <= configured_next;
                out_valid_reg  <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            action_reg   <= action_next;
            sel_reg      <= sel_next;
            tx_len_reg   <= tx_len_next;
            addr_upd_reg <= addr_upd_next;
            bulk_reg     <= bulk_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.action            = action_reg;
    assign rsp.descriptor_select = sel_reg;
    assign rsp.tx_length         = tx_len_reg;
    assign rsp.device_address    = cur_addr_reg;
    assign rsp.address_updated   = addr_upd_reg;
    assign rsp.configured        = configured_reg;
    assign rsp.start_bulk_in     = bulk_reg;

    `UCER_ASSERT_IMPL(a_bulk_means_configured, clk, rst_n, out_valid_reg && bulk_reg, configured_reg, "bulk start without configured flag")
    `UCER_ASSERT_IMPL(a_unused_fields_zero, clk, rst_n, out_valid_reg && action_reg != ucer_pkg::ACT_SEND, sel_reg == 3'd0 && tx_len_reg == '0, "descriptor fields set on non-send action")
    `UCER_ASSERT_IMPL(a_done_addr_nonzero, clk, rst_n, out_valid_reg && addr_upd_reg && action_reg == ucer_pkg::ACT_DONE, cur_addr_reg != '0, "address applied as zero")
    `UCER_ASSERT_NEXT(a_pop_loads_output, clk, rst_n, pop, out_valid_reg, "popped command produced no result")

endmodule

// ----- hw/rtl/usb_control_endpoint_responder.sv -----
`timescale 1ns / 1ps
// channel  dir  handshake      payload
// req      in   valid/ready    event_kind, received_bytes, request_*
// rsp      out  valid/ready    action, descriptor_select, tx_length, address/config status
// cfg      in   cfg_we only    cfg_index, cfg_wdata
// rate: one item per cycle sustained while rsp.ready holds; results pass the queue, then the output register
// the front classifies in the acceptance cycle, the back updates state when it pops the command
// req.ready falls only when the command queue is full (output stalled)
// reset clears queue, pending values, address and configured flag; no clearing pass
// configuration registers return to their defaults on reset

module usb_control_endpoint_responder #(
    parameter int QUEUE_DEPTH = ucer_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ucer_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ucer_pkg::LEN_W-1:0]        cfg_wdata,
    ucer_event_if.sink                        req,
    ucer_result_if.source                     rsp
);

    ucer_pkg::cfg_t  cfg_reg;
    ucer_pkg::cmd_t  front_cmd;
    ucer_pkg::cmd_t  head_cmd;
    logic            push;
    logic            pop;
    logic            not_full;
    logic            not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.config_value <= ucer_pkg::CONFIG_VALUE_RST;
            cfg_reg.desc_len     <= ucer_pkg::DESC_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (ucer_pkg::reg_index_t'(cfg_index))
                ucer_pkg::REG_CONFIG_VALUE:
                    cfg_reg.config_value <= cfg_wdata[ucer_pkg::CONF_W-1:0];
                ucer_pkg::REG_DEVICE_LEN:  cfg_reg.desc_len[0] <= cfg_wdata;
                ucer_pkg::REG_CONFIG_LEN:  cfg_reg.desc_len[1] <= cfg_wdata;
                ucer_pkg::REG_QUAL_LEN:    cfg_reg.desc_len[2] <= cfg_wdata;
                ucer_pkg::REG_LANG_LEN:    cfg_reg.desc_len[3] <= cfg_wdata;
                ucer_pkg::REG_VENDOR_LEN:  cfg_reg.desc_len[4] <= cfg_wdata;
                ucer_pkg::REG_PRODUCT_LEN: cfg_reg.desc_len[5] <= cfg_wdata;
                ucer_pkg::REG_SERIAL_LEN:  cfg_reg.desc_len[6] <= cfg_wdata;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    ucer_front u_front (
        .req         (req),
        .cfg         (cfg_reg),
        .queue_ready (not_full),
        .push        (push),
        .cmd         (front_cmd)
    );

    ucer_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (pop),
        .not_full  (not_full),
        .not_empty (not_empty),
        .head      (head_cmd)
    );

    ucer_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .config_value (cfg_reg.config_value),
        .cmd_valid    (not_empty),
        .cmd          (head_cmd),
        .pop          (pop),
        .rsp          (rsp)
    );

endmodule
